// File: hdl/avp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_pkg
// Shared types and constants for the window average and peak block.
// ----------------------------------------------------------------------------
package avp_pkg;

    // Digit width of the serial accumulators
    localparam int DIGIT_BITS   = 8;
    // Width of the running overrun counter
    localparam int OVERRUN_BITS = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: hdl/avp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_in_if
// Input channel: one beat carries a sample pair or a snapshot request.
// ----------------------------------------------------------------------------
interface avp_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic [SAMPLE_BITS-1:0] voltage_sample;
    logic                   overrun_flag;

    modport source (
        output valid,
        output func,
        output current_sample,
        output voltage_sample,
        output overrun_flag,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  current_sample,
        input  voltage_sample,
        input  overrun_flag,
        output ready
    );
endinterface

// File: hdl/avp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_out_if
// Output channel: one beat carries one window report.
// ----------------------------------------------------------------------------
interface avp_out_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] recent_current;
    logic [SAMPLE_BITS-1:0] recent_voltage;
    logic [SAMPLE_BITS-1:0] average_current;
    logic [SAMPLE_BITS-1:0] average_voltage;
    logic [SAMPLE_BITS-1:0] max_current;
    logic [COUNT_BITS-1:0]  window_count;
    logic [31:0]            overrun_total;

    modport source (
        output valid,
        output recent_current,
        output recent_voltage,
        output average_current,
        output average_voltage,
        output max_current,
        output window_count,
        output overrun_total,
        input  ready
    );

    modport sink (
        input  valid,
        input  recent_current,
        input  recent_voltage,
        input  average_current,
        input  average_voltage,
        input  max_current,
        input  window_count,
        input  overrun_total,
        output ready
    );
endinterface

// File: hdl/adc_window_average_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_window_average_peak
// Window average and peak detector for paired current/voltage samples.
// ----------------------------------------------------------------------------
// Input channel (samples): a beat with func 0 adds a sample pair to the
// window; a beat with func 1 closes the window and yields one report beat
// on the output channel (results). Both use valid/ready.
// cfg_wr_en/cfg_wr_data load the current offset; write only while idle.
// Sample beats: a new beat is taken only once the byte-serial adders are
// done; the pace is set by the one that updates the 32-bit overrun counter
// (the window sums never take longer).
// Snapshot of an empty window: the report is registered from the put state.
// Otherwise one shared bit-serial divider runs twice, current sum then
// voltage sum, and the report is registered from the put state after
// both divisions; the next beat is taken the cycle after that.
// A stalled receiver holds the report; samples are still taken, and a
// further snapshot waits for the output register to empty.
// Reset clears all sums, counts, latest values and the offset.
// ----------------------------------------------------------------------------
module adc_window_average_peak #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [SAMPLE_BITS-1:0] cfg_wr_data,
    avp_in_if.sink                 samples,
    avp_out_if.source              results
);
    import avp_pkg::*;

    localparam int TOTAL_BITS = SAMPLE_BITS + COUNT_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIVC = 2'd1;
    localparam logic [1:0] ST_DIVV = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] offset_reg;
    logic [SAMPLE_BITS-1:0] last_cur_reg, last_vol_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [SAMPLE_BITS-1:0] quot_c_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] r_lcur_reg, r_lvol_reg, r_acur_reg, r_avol_reg, r_peak_reg;
    logic [COUNT_BITS-1:0]  r_count_reg;
    logic [OVERRUN_BITS-1:0] r_ovr_reg;

    logic                   in_acc, sample_acc, snap_acc;
    logic                   full, empty;
    logic                   tot_start;
    logic                   cur_busy, vol_busy, ovr_busy, acc_busy;
    logic [TOTAL_BITS-1:0]  cur_total, vol_total;
    logic [OVERRUN_BITS-1:0] ovr_total;
    logic                   div_start;
    logic [TOTAL_BITS-1:0]  div_dividend;
    div_status_t            div_stat;
    logic [SAMPLE_BITS-1:0] div_quot;
    logic                   put_go;
    logic [SAMPLE_BITS-1:0] avg_c_src, avg_v_src, peak_src;

    function automatic logic [SAMPLE_BITS-1:0] less_offset(
        input logic [SAMPLE_BITS-1:0] v,
        input logic [SAMPLE_BITS-1:0] off
    );
        less_offset = (v > off) ? (v - off) : '0;
    endfunction

    assign acc_busy      = cur_busy || vol_busy || ovr_busy;
    assign samples.ready = (state_reg == ST_IDLE) && !acc_busy;
    assign in_acc        = samples.valid && samples.ready;
    assign sample_acc    = in_acc && !samples.func;
    assign snap_acc      = in_acc && samples.func;
    assign full          = &count_reg;
    assign empty         = (count_reg == '0);
    assign tot_start     = sample_acc && !full;
    assign put_go        = (state_reg == ST_PUT) && (!out_valid_reg || results.ready);

    avp_serial_acc #(.WIDTH(TOTAL_BITS), .ADD_BITS(SAMPLE_BITS)) u_cur_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (tot_start),
        .clear  (put_go),
        .addend (samples.current_sample),
        .busy   (cur_busy),
        .value  (cur_total)
    );

    avp_serial_acc #(.WIDTH(TOTAL_BITS), .ADD_BITS(SAMPLE_BITS)) u_vol_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (tot_start),
        .clear  (put_go),
        .addend (samples.voltage_sample),
        .busy   (vol_busy),
        .value  (vol_total)
    );

    // overrun total survives snapshots
    avp_serial_acc #(.WIDTH(OVERRUN_BITS), .ADD_BITS(1)) u_ovr_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sample_acc),
        .clear  (1'b0),
        .addend (samples.overrun_flag),
        .busy   (ovr_busy),
        .value  (ovr_total)
    );

    // current sum first, then voltage sum
    assign div_start    = (snap_acc && !empty) || ((state_reg == ST_DIVC) && div_stat.done);
    assign div_dividend = (state_reg == ST_DIVC) ? vol_total : cur_total;

    avp_div #(.QUOT_BITS(SAMPLE_BITS), .DIV_BITS(COUNT_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .status   (div_stat),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (snap_acc)
                begin
                    state_next = empty ? ST_PUT : ST_DIVC;
                end
            end
            ST_DIVC:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DIVV;
                end
            end
            ST_DIVV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (put_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // an empty window reports the latest values in place of averages
    assign avg_c_src = empty ? last_cur_reg : quot_c_reg;
    assign avg_v_src = empty ? last_vol_reg : div_quot;
    assign peak_src  = empty ? last_cur_reg : peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            last_cur_reg  <= '0;
            last_vol_reg  <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            if (sample_acc)
            begin
                last_cur_reg <= samples.current_sample;
                last_vol_reg <= samples.voltage_sample;
                if (!full)
                begin
                    if (empty || (samples.current_sample > peak_reg))
                    begin
                        peak_reg <= samples.current_sample;
                    end
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
            end
            if (put_go)
            begin
                peak_reg  <= '0;
                count_reg <= '0;
            end
            if (put_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIVC) && div_stat.done)
        begin
            quot_c_reg <= div_quot;
        end
        if (put_go)
        begin
            r_lcur_reg  <= less_offset(last_cur_reg, offset_reg);
            r_lvol_reg  <= last_vol_reg;
            r_acur_reg  <= less_offset(avg_c_src, offset_reg);
            r_avol_reg  <= avg_v_src;
            r_peak_reg  <= less_offset(peak_src, offset_reg);
            r_count_reg <= count_reg;
            r_ovr_reg   <= ovr_total;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.recent_current  = r_lcur_reg;
    assign results.recent_voltage  = r_lvol_reg;
    assign results.average_current = r_acur_reg;
    assign results.average_voltage = r_avol_reg;
    assign results.max_current     = r_peak_reg;
    assign results.window_count    = r_count_reg;
    assign results.overrun_total   = r_ovr_reg;

endmodule

// File: hdl/avp_serial_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_serial_acc
// Digit-serial accumulator: adds an operand one byte per cycle into a
// rotating register, which is back in place once busy drops.
// ----------------------------------------------------------------------------
module avp_serial_acc #(
    parameter int WIDTH    = 28,   // must exceed one digit
    parameter int ADD_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                clear,
    input  logic [ADD_BITS-1:0] addend,
    output logic                busy,
    output logic [WIDTH-1:0]    value
);
    import avp_pkg::*;

    localparam int NDIG  = (WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD   = NDIG * DIGIT_BITS;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [PAD-1:0]        acc_reg, acc_next;
    logic [PAD-1:0]        opnd_reg, opnd_next;
    logic                  carry_reg, carry_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PAD-1:0]        ext;
    logic [DIGIT_BITS-1:0] op_b;
    logic                  c_in;
    logic [DIGIT_BITS:0]   sum;
    logic                  step;

    assign ext  = PAD'(addend);
    assign step = start || (cnt_reg != '0);
    assign op_b = start ? ext[DIGIT_BITS-1:0] : opnd_reg[DIGIT_BITS-1:0];
    assign c_in = start ? 1'b0 : carry_reg;
    assign sum  = {1'b0, acc_reg[DIGIT_BITS-1:0]} + {1'b0, op_b}
                + (DIGIT_BITS+1)'(c_in);

    always_comb
    begin
        acc_next   = acc_reg;
        opnd_next  = opnd_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (step)
        begin
            // rotate the fresh digit in at the top
            acc_next   = {sum[DIGIT_BITS-1:0], acc_reg[PAD-1:DIGIT_BITS]};
            carry_next = sum[DIGIT_BITS];
            opnd_next  = start ? (ext >> DIGIT_BITS) : (opnd_reg >> DIGIT_BITS);
            cnt_next   = start ? CNT_W'(NDIG - 1) : cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            carry_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            carry_reg <= carry_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
    end

    assign busy  = (cnt_reg != '0);
    assign value = acc_reg[WIDTH-1:0];

endmodule

// File: hdl/avp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_div
// Bit-serial restoring divider, one quotient bit per cycle. The quotient
// must fit QUOT_BITS, so the top of the dividend is already below divisor.
// ----------------------------------------------------------------------------
module avp_div #(
    parameter int QUOT_BITS = 12,
    parameter int DIV_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [QUOT_BITS+DIV_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]           divisor,
    output avp_pkg::div_status_t          status,
    output logic [QUOT_BITS-1:0]          quotient
);
    import avp_pkg::*;

    localparam int CNT_W = $clog2(QUOT_BITS + 1);

    logic [DIV_BITS-1:0]  rem_reg, rem_next;
    logic [QUOT_BITS-1:0] q_reg, q_next;
    logic [DIV_BITS-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg;
    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS:0]    diff;
    logic                 ge;

    assign trial = {rem_reg, q_reg[QUOT_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = dividend[QUOT_BITS+DIV_BITS-1:QUOT_BITS];
            q_next   = dividend[QUOT_BITS-1:0];
            dvs_next = divisor;
            cnt_next = CNT_W'(QUOT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            q_next   = {q_reg[QUOT_BITS-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= !start && (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = q_reg;

endmodule

// File: hdl/avp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_chk
// Port-level checks for the window average and peak block.
// ----------------------------------------------------------------------------
module avp_chk #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_func,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] recent_current,
    input logic [SAMPLE_BITS-1:0] recent_voltage,
    input logic [SAMPLE_BITS-1:0] average_current,
    input logic [SAMPLE_BITS-1:0] average_voltage,
    input logic [SAMPLE_BITS-1:0] max_current,
    input logic [COUNT_BITS-1:0]  window_count
);

    // hold a stalled report beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("report beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(window_count) && $stable(average_voltage))
        else $error("report payload changed while stalled");

    // a sample keeps the serial adders busy, so input is not ready in the cycle after it is taken
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_func |=> !in_ready)
        else $error("input taken while sums still updating");

    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (window_count == '0) |->
            (average_current == recent_current) && (max_current == recent_current)
            && (average_voltage == recent_voltage))
        else $error("empty window must report latest values");

endmodule

bind adc_window_average_peak avp_chk #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_avp_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (samples.valid),
    .in_ready        (samples.ready),
    .in_func         (samples.func),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .recent_current  (results.recent_current),
    .recent_voltage  (results.recent_voltage),
    .average_current (results.average_current),
    .average_voltage (results.average_voltage),
    .max_current     (results.max_current),
    .window_count    (results.window_count)
);

// File: tb/adc_window_average_peak_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_window_average_peak_tb
// Self-checking bench for the window average and peak detector.
// ----------------------------------------------------------------------------
// A short table of sample and snapshot beats runs first. Its obvious rows
// carry their report typed in; the rest, and all random windows after it,
// are checked against a cycle-free model of the window sums. The offset is
// reloaded between phases while the block is idle. One phase starves the
// report channel for a long stretch. Sender bursts and receiver stalls are
// random.
// ----------------------------------------------------------------------------
module adc_window_average_peak_tb;

    localparam int SAMPLE_BITS  = 12;
    localparam int COUNT_BITS   = 16;
    localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
    localparam int OVR_BITS     = avp_pkg::OVERRUN_BITS;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int DRAIN_CYCLES = 2 * SAMPLE_BITS + 3 + 13;
    localparam int LONG_HOLD    = 600;
    localparam int PHASE_ITEMS  = 340;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SHOW_LIMIT   = 10;

    typedef enum logic {
        OP_SAMPLE   = 1'b0,
        OP_SNAPSHOT = 1'b1
    } window_op_e;

    typedef struct packed {
        window_op_e             op;
        logic [SAMPLE_BITS-1:0] cur;
        logic [SAMPLE_BITS-1:0] vol;
        logic                   ovr;
    } sample_beat_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] recent_current;
        logic [SAMPLE_BITS-1:0] recent_voltage;
        logic [SAMPLE_BITS-1:0] average_current;
        logic [SAMPLE_BITS-1:0] average_voltage;
        logic [SAMPLE_BITS-1:0] max_current;
        logic [COUNT_BITS-1:0]  window_count;
        logic [OVR_BITS-1:0]    overrun_total;
    } window_report_t;

    typedef struct packed {
        sample_beat_t   beat;
        logic           typed;
        window_report_t report;
    } directed_row_t;

    localparam window_report_t NO_REPORT = '0;
    localparam int DIRECTED_ROWS = 18;

    // Rows with typed = 1 carry a report that can be read off directly.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_SNAPSHOT, 12'h000, 12'h000, 1'b0}, 1'b1,
          '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 32'd0}},
        '{'{OP_SAMPLE,   12'hFFF, 12'hFFF, 1'b1}, 1'b0, NO_REPORT},
        '{'{OP_SAMPLE,   12'h000, 12'h000, 1'b0}, 1'b0, NO_REPORT},
        '{'{OP_SNAPSHOT, 12'hFFF, 12'hFFF, 1'b1}, 1'b1,
          '{12'd0, 12'd0, 12'd2047, 12'd2047, 12'd4095, 16'd2, 32'd1}},
        '{'{OP_SNAPSHOT, 12'hABC, 12'h543, 1'b0}, 1'b1,
          '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 32'd1}},
        '{'{OP_SAMPLE,   12'hFFF, 12'h000, 1'b1}, 1'b0, NO_REPORT},
        '{'{OP_SNAPSHOT, 12'h000, 12'hFFF, 1'b0}, 1'b1,
          '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 16'd1, 32'd2}},
        '{'{OP_SAMPLE,   12'h000, 12'hFFF, 1'b0}, 1'b0, NO_REPORT},
        '{'{OP_SNAPSHOT, 12'h123, 12'h456, 1'b1}, 1'b1,
          '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 16'd1, 32'd2}},
        '{'{OP_SAMPLE,   12'h555, 12'hAAA, 1'b1}, 1'b0, NO_REPORT},
        '{'{OP_SAMPLE,   12'hAAA, 12'h555, 1'b0}, 1'b0, NO_REPORT},
        '{'{OP_SAMPLE,   12'h800, 12'h7FF, 1'b1}, 1'b0, NO_REPORT},
        '{'{OP_SAMPLE,   12'h001, 12'hFFE, 1'b0}, 1'b0, NO_REPORT},
        '{'{OP_SNAPSHOT, 12'h000, 12'h000, 1'b0}, 1'b0, NO_REPORT},
        '{'{OP_SNAPSHOT, 12'hFFF, 12'h000, 1'b1}, 1'b1,
          '{12'd1, 12'd4094, 12'd1, 12'd4094, 12'd1, 16'd0, 32'd4}},
        '{'{OP_SAMPLE,   12'h7FF, 12'h800, 1'b1}, 1'b0, NO_REPORT},
        '{'{OP_SAMPLE,   12'h7FF, 12'h800, 1'b0}, 1'b0, NO_REPORT},
        '{'{OP_SNAPSHOT, 12'h000, 12'h000, 1'b0}, 1'b0, NO_REPORT}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [SAMPLE_BITS-1:0] cfg_wr_data;

    avp_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples ();
    avp_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) results ();

    adc_window_average_peak #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples),
        .results     (results)
    );

    // Mirror of the block state
    logic [SAMPLE_BITS-1:0] cur_offset;
    logic [SAMPLE_BITS-1:0] last_cur;
    logic [SAMPLE_BITS-1:0] last_vol;
    logic [SUM_BITS-1:0]    cur_sum;
    logic [SUM_BITS-1:0]    vol_sum;
    logic [SAMPLE_BITS-1:0] peak_cur;
    logic [COUNT_BITS-1:0]  win_count;
    logic [OVR_BITS-1:0]    flagged_total;

    window_report_t reports_due [$];
    int unsigned    mismatch_count;
    int unsigned    report_index;
    int unsigned    cycle_count;
    int unsigned    burst_left;
    bit             hold_go;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [SAMPLE_BITS-1:0] less_offset(logic [SUM_BITS-1:0] v);
        logic [SUM_BITS-1:0] diff;
        diff = v - SUM_BITS'(cur_offset);
        return (v > SUM_BITS'(cur_offset)) ? diff[SAMPLE_BITS-1:0] : '0;
    endfunction

    // Fold one beat into the window; return 1 when it closes the window.
    function automatic bit accumulate_or_report(sample_beat_t b, output window_report_t r);
        logic [SUM_BITS-1:0] quotient;
        r = '0;
        if (b.op == OP_SAMPLE)
        begin
            last_cur      = b.cur;
            last_vol      = b.vol;
            flagged_total = flagged_total + OVR_BITS'(b.ovr);
            if (win_count < COUNT_MAX)
            begin
                cur_sum = cur_sum + SUM_BITS'(b.cur);
                vol_sum = vol_sum + SUM_BITS'(b.vol);
                if (win_count == 0 || b.cur > peak_cur)
                    peak_cur = b.cur;
                win_count = win_count + COUNT_BITS'(1);
            end
            return 1'b0;
        end
        r.recent_current = less_offset(SUM_BITS'(last_cur));
        r.recent_voltage = last_vol;
        if (win_count == 0)
        begin
            // empty window: latest values stand in
            r.average_current = r.recent_current;
            r.average_voltage = last_vol;
            r.max_current     = r.recent_current;
            r.window_count    = '0;
        end
        else
        begin
            r.average_current = less_offset(cur_sum / SUM_BITS'(win_count));
            quotient          = vol_sum / SUM_BITS'(win_count);
            r.average_voltage = quotient[SAMPLE_BITS-1:0];
            r.max_current     = less_offset(SUM_BITS'(peak_cur));
            r.window_count    = win_count;
        end
        r.overrun_total = flagged_total;
        cur_sum   = '0;
        vol_sum   = '0;
        peak_cur  = '0;
        win_count = '0;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_reading();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    function automatic sample_beat_t random_beat(window_op_e op);
        sample_beat_t b;
        b.op  = op;
        b.cur = random_reading();
        b.vol = random_reading();
        b.ovr = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // Offer one beat, hold it until taken, then update the expected reports.
    task automatic drive_beat(sample_beat_t b, logic typed, window_report_t typed_report);
        int unsigned    gap;
        window_report_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                samples.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        samples.valid          <= 1'b1;
        samples.func           <= b.op;
        samples.current_sample <= b.cur;
        samples.voltage_sample <= b.vol;
        samples.overrun_flag   <= b.ovr;
        do
            @(posedge clk);
        while (!samples.ready);
        if (accumulate_or_report(b, predicted))
            reports_due.push_back(typed ? typed_report : predicted);
    endtask

    // Drop valid, wait for every report, then let a sample beat finish.
    task automatic wait_idle();
        samples.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(logic [SAMPLE_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_offset = value;
    endtask

    task automatic run_random_windows(int unsigned item_budget);
        int unsigned issued;
        int unsigned win_len;
        int unsigned pick;
        issued = 0;
        while (issued < item_budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                win_len = 0;
            else if (pick < 80)
                win_len = $urandom_range(1, 20);
            else if (pick < 96)
                win_len = $urandom_range(21, 80);
            else
                win_len = $urandom_range(81, 200);
            repeat (win_len) drive_beat(random_beat(OP_SAMPLE), 1'b0, NO_REPORT);
            drive_beat(random_beat(OP_SNAPSHOT), 1'b0, NO_REPORT);
            issued += win_len + 1;
        end
    endtask

    // Report channel: own stall pattern, plus one long hold-off on request.
    initial
    begin : report_sink
        int unsigned     hold_left;
        bit              hold_seen;
        logic [15:0]     stall_bits;
        int unsigned     bits_age;
        int unsigned     bit_pos;
        hold_left     = 0;
        hold_seen     = 1'b0;
        stall_bits    = '0;
        bits_age      = 0;
        bit_pos       = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                results.ready <= 1'b0;
            else if (hold_go != hold_seen)
            begin
                hold_seen = hold_go;
                hold_left = LONG_HOLD;
                results.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
            begin
                if (bits_age == 0)
                begin
                    stall_bits = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
                    bits_age   = $urandom_range(32, 256);
                end
                bits_age--;
                results.ready <= ~stall_bits[bit_pos % 16];
                bit_pos++;
            end
        end
    end

    always @(posedge clk)
    begin
        window_report_t got;
        window_report_t want;
        if (rst_n && results.valid && results.ready)
        begin
            got.recent_current  = results.recent_current;
            got.recent_voltage  = results.recent_voltage;
            got.average_current = results.average_current;
            got.average_voltage = results.average_voltage;
            got.max_current     = results.max_current;
            got.window_count    = results.window_count;
            got.overrun_total   = results.overrun_total;
            if (reports_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("report %0d arrived with none pending", report_index);
            end
            else
            begin
                want = reports_due.pop_front();
                if (got.recent_current  !== want.recent_current  ||
                    got.recent_voltage  !== want.recent_voltage  ||
                    got.average_current !== want.average_current ||
                    got.average_voltage !== want.average_voltage ||
                    got.max_current     !== want.max_current     ||
                    got.window_count    !== want.window_count    ||
                    got.overrun_total   !== want.overrun_total)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                    begin
                        $display("report %0d expected lc=%0d lv=%0d ac=%0d av=%0d pk=%0d n=%0d ov=%0d",
                                 report_index, want.recent_current, want.recent_voltage,
                                 want.average_current, want.average_voltage,
                                 want.max_current, want.window_count, want.overrun_total);
                        $display("report %0d actual   lc=%0d lv=%0d ac=%0d av=%0d pk=%0d n=%0d ov=%0d",
                                 report_index, got.recent_current, got.recent_voltage,
                                 got.average_current, got.average_voltage,
                                 got.max_current, got.window_count, got.overrun_total);
                    end
                end
            end
            report_index++;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at cycle limit");
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        samples.valid          = 1'b0;
        samples.func           = OP_SAMPLE;
        samples.current_sample = '0;
        samples.voltage_sample = '0;
        samples.overrun_flag   = 1'b0;
        cur_offset             = '0;
        last_cur               = '0;
        last_vol               = '0;
        cur_sum                = '0;
        vol_sum                = '0;
        peak_cur               = '0;
        win_count              = '0;
        flagged_total          = '0;
        mismatch_count         = 0;
        report_index           = 0;
        burst_left             = 0;
        hold_go                = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            drive_beat(directed_rows[i].beat, directed_rows[i].typed,
                       directed_rows[i].report);

        wait_idle();
        write_offset(12'd4095);
        run_random_windows(PHASE_ITEMS);

        // starve the report channel while beats keep coming
        wait_idle();
        write_offset(12'd1);
        hold_go <= ~hold_go;
        run_random_windows(PHASE_ITEMS);

        wait_idle();
        write_offset(SAMPLE_BITS'($urandom_range(2, SAMPLE_MAX - 2)));
        run_random_windows(PHASE_ITEMS);

        wait_idle();
        write_offset(12'd2048);
        run_random_windows(PHASE_ITEMS);

        wait_idle();
        write_offset(12'd0);
        run_random_windows(PHASE_ITEMS);

        wait_idle();
        if (mismatch_count == 0 && reports_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
